// ===== sv/ccm_pkg.sv =====
// shared types and constants for the cell coordinate mapper
// no dependencies; imported by every module of the block
package ccm_pkg;

  localparam int unsigned FIELDS = 4;
  localparam int unsigned CW     = 16;  // coordinate width
  localparam int unsigned SW     = 11;  // size register width
  localparam int unsigned RW     = 12;  // partial remainder width
  localparam int unsigned UW     = 17;  // signed used coordinate width
  localparam int unsigned WW     = 10;  // wrapped output width
  localparam int unsigned IW     = 40;  // linear index width
  localparam int unsigned STEPS  = 4;   // dividend bits per stage

  typedef enum logic [2:0] {
    REG_DIM_COUNT = 3'd0,
    REG_SIZE_0    = 3'd1,
    REG_SIZE_1    = 3'd2,
    REG_SIZE_2    = 3'd3,
    REG_SIZE_3    = 3'd4,
    REG_WRAP      = 3'd5
  } reg_idx_t;

  typedef logic [FIELDS-1:0][SW-1:0] size_vec_t;

  typedef struct packed {
    logic                        vld;
    logic [FIELDS-1:0]           act;
    logic                        in_rng;
    logic [FIELDS-1:0]           neg;
    logic [FIELDS-1:0][CW-1:0]   c;
    logic [FIELDS-1:0][CW-1:0]   mag;
    logic [FIELDS-1:0][RW-1:0]   rem;
  } rem_pipe_t;

endpackage

// ===== sv/cell_coordinate_mapper_core.sv =====
// top level of the cell coordinate mapper
// depends on ccm_pkg, ccm_rem_stage, ccm_index

// Maps a signed coordinate tuple of up to four dimensions to wrapped
// coordinates, an in-range flag and a mixed-radix linear index, first
// dimension fastest. A new transaction may start in every cycle (busy
// is always low); its result appears on the outputs with done high
// one cycle wide, in order, after passing through the pipeline: one
// capture register, the floored-modulo unit of four stages of four
// restoring steps each, one correction stage, one multiplier stage,
// one summing stage and the output register.
// Configuration writes are always ready; since the pipeline reads the
// registers at several stages, issue them only while no transaction is
// in flight.
module cell_coordinate_mapper_core import ccm_pkg::*; #(
  parameter int unsigned NUM_DIMS   = 4,
  parameter int unsigned MAX_EXTENT = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic signed [CW-1:0] coord_0,
  input  logic signed [CW-1:0] coord_1,
  input  logic signed [CW-1:0] coord_2,
  input  logic signed [CW-1:0] coord_3,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output logic              done,
  output logic [WW-1:0]     wrapped_0,
  output logic [WW-1:0]     wrapped_1,
  output logic [WW-1:0]     wrapped_2,
  output logic [WW-1:0]     wrapped_3,
  output logic [IW-1:0]     linear_index,
  output logic              inside_res
);

  localparam int unsigned CAP = (NUM_DIMS < FIELDS) ? NUM_DIMS : FIELDS;

  logic [2:0]      dim_count;
  logic [SW-1:0]   size_r [FIELDS];
  logic            wrap_enable;
  size_vec_t       esz;
  logic [2:0]      n_act;
  rem_pipe_t       s0, s0_next, s1, s2, s3, s4;
  logic                      f_vld;
  logic                      f_inside;
  logic [FIELDS-1:0][UW-1:0] f_u;
  logic [FIELDS-1:0][UW-1:0] u_next;
  logic                      x_vld;
  logic [IW-1:0]             x_index;
  logic                      in1, in2;
  logic [FIELDS-1:0][WW-1:0] w1, w2;
  logic signed [CW-1:0]      cin [FIELDS];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count   <= 3'd2;
      wrap_enable <= 1'b1;
      for (int i = 0; i < FIELDS; i++) size_r[i] <= SW'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DIM_COUNT: dim_count   <= cfg_data[2:0];
        REG_SIZE_0:    size_r[0]   <= cfg_data[SW-1:0];
        REG_SIZE_1:    size_r[1]   <= cfg_data[SW-1:0];
        REG_SIZE_2:    size_r[2]   <= cfg_data[SW-1:0];
        REG_SIZE_3:    size_r[3]   <= cfg_data[SW-1:0];
        REG_WRAP:      wrap_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < FIELDS; i++) begin
      if (size_r[i] == '0) esz[i] = SW'(1);
      else if (32'(size_r[i]) > MAX_EXTENT) esz[i] = SW'(MAX_EXTENT);
      else esz[i] = size_r[i];
    end
    if (dim_count == 3'd0) n_act = 3'd1;
    else if (32'(dim_count) > CAP) n_act = 3'(CAP);
    else n_act = dim_count;
  end

  assign cin[0] = coord_0;
  assign cin[1] = coord_1;
  assign cin[2] = coord_2;
  assign cin[3] = coord_3;

  // capture: activity, range check, sign and magnitude
  always_comb begin
    s0_next        = '0;
    s0_next.vld    = start;
    s0_next.in_rng = 1'b1;
    for (int i = 0; i < FIELDS; i++) begin
      s0_next.act[i] = (3'(i) < n_act);
      s0_next.c[i]   = cin[i];
      s0_next.neg[i] = cin[i][CW-1];
      s0_next.mag[i] = cin[i][CW-1] ? (~cin[i] + 1'b1) : cin[i];
      if (s0_next.act[i] &&
          (cin[i][CW-1] || (cin[i] >= $signed({5'b0, esz[i]}))))
        s0_next.in_rng = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s0 <= '0;
    else s0 <= s0_next;
  end

  ccm_rem_stage #(.TOP_BIT(15)) u_rem0 (.clk, .rst, .esz, .d(s0), .q(s1));
  ccm_rem_stage #(.TOP_BIT(11)) u_rem1 (.clk, .rst, .esz, .d(s1), .q(s2));
  ccm_rem_stage #(.TOP_BIT(7))  u_rem2 (.clk, .rst, .esz, .d(s2), .q(s3));
  ccm_rem_stage #(.TOP_BIT(3))  u_rem3 (.clk, .rst, .esz, .d(s3), .q(s4));

  // floored correction for negative dividends, raw value with wrap off
  always_comb begin
    for (int i = 0; i < FIELDS; i++) begin
      if (!s4.act[i]) u_next[i] = '0;
      else if (!wrap_enable) u_next[i] = UW'($signed(s4.c[i]));
      else if (s4.neg[i] && s4.rem[i] != '0)
        u_next[i] = UW'({1'b0, esz[i]} - s4.rem[i]);
      else u_next[i] = UW'(s4.rem[i]);
    end
  end

  always_ff @(posedge clk) begin
    f_u      <= u_next;
    f_inside <= s4.in_rng;
    in1      <= f_inside;
    in2      <= in1;
    for (int i = 0; i < FIELDS; i++) w1[i] <= f_u[i][WW-1:0];
    w2 <= w1;
    if (rst) f_vld <= 1'b0;
    else f_vld <= s4.vld;
  end

  ccm_index u_index (
    .clk, .rst, .esz,
    .in_vld(f_vld), .u(f_u),
    .out_vld(x_vld), .index(x_index)
  );

  always_ff @(posedge clk) begin
    linear_index <= x_index;
    inside_res   <= in2;
    wrapped_0    <= w2[0];
    wrapped_1    <= w2[1];
    wrapped_2    <= w2[2];
    wrapped_3    <= w2[3];
    if (rst) done <= 1'b0;
    else done <= x_vld;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##9 done) else $error("result missing after start");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 9)) else $error("result without a transaction");
  a_wrap_range: assert property (@(posedge clk) disable iff (rst)
    (done && wrap_enable) |-> ({1'b0, wrapped_0} < {1'b0, esz[0]}))
    else $error("wrapped coordinate out of range");
`endif

endmodule

// ===== sv/ccm_rem_stage.sv =====
// one stage of the restoring remainder unit: four dividend bits per stage
// depends on ccm_pkg
module ccm_rem_stage import ccm_pkg::*; #(
  parameter int unsigned TOP_BIT = 15
) (
  input  logic      clk,
  input  logic      rst,
  input  size_vec_t esz,
  input  rem_pipe_t d,
  output rem_pipe_t q
);

  rem_pipe_t q_next;

  always_comb begin
    logic [RW-1:0] r;
    q_next = d;
    for (int i = 0; i < FIELDS; i++) begin
      r = d.rem[i];
      for (int k = 0; k < STEPS; k++) begin
        r = {r[RW-2:0], d.mag[i][TOP_BIT-k]};
        if (r >= {1'b0, esz[i]}) r = r - {1'b0, esz[i]};
      end
      q_next.rem[i] = r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) q <= '0;
    else q <= q_next;
  end

endmodule

// ===== sv/ccm_index.sv =====
// mixed-radix index: radix products, per-dimension products, final sum
// depends on ccm_pkg
module ccm_index import ccm_pkg::*; (
  input  logic                              clk,
  input  logic                              rst,
  input  size_vec_t                         esz,
  input  logic                              in_vld,
  input  logic [FIELDS-1:0][UW-1:0]         u,
  output logic                              out_vld,
  output logic [IW-1:0]                     index
);

  logic [2*SW-1:0]          m2;
  logic [3*SW-1:0]          m3;
  logic                     p_vld;
  logic [FIELDS-1:0][IW-1:0] p;

  // radix products are registered: m2 from the size registers, m3 from m2
  always_ff @(posedge clk) begin
    m2 <= esz[0] * esz[1];
    m3 <= m2 * esz[2];
  end

  always_ff @(posedge clk) begin
    p[0] <= IW'($signed(u[0]));
    p[1] <= IW'($signed(u[1]) * $signed({1'b0, esz[0]}));
    p[2] <= IW'($signed(u[2]) * $signed({1'b0, m2}));
    p[3] <= IW'($signed(u[3]) * $signed({1'b0, m3}));
    index <= p[0] + p[1] + p[2] + p[3];
    if (rst) begin
      p_vld   <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      p_vld   <= in_vld;
      out_vld <= p_vld;
    end
  end

endmodule

// ===== tb/sv/cell_coordinate_mapper_core_tb.sv =====
`timescale 1ns / 1ps
// testbench for cell_coordinate_mapper_core: directed and random coordinate tuples
// under several dim/size/wrap settings, checked against an in-bench predictor
// depends on ccm_pkg and cell_coordinate_mapper_core
module cell_coordinate_mapper_core_tb;
  import ccm_pkg::*;

  typedef struct packed {
    logic [WW-1:0] w0;
    logic [WW-1:0] w1;
    logic [WW-1:0] w2;
    logic [WW-1:0] w3;
    logic [IW-1:0] lin;
    logic          ins;
  } cell_map_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [CW-1:0] coord_0, coord_1, coord_2, coord_3;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;
  logic done;
  logic [WW-1:0] wrapped_0, wrapped_1, wrapped_2, wrapped_3;
  logic [IW-1:0] linear_index;
  logic inside_res;

  cell_coordinate_mapper_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coord_0(coord_0), .coord_1(coord_1), .coord_2(coord_2), .coord_3(coord_3),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done),
    .wrapped_0(wrapped_0), .wrapped_1(wrapped_1), .wrapped_2(wrapped_2),
    .wrapped_3(wrapped_3), .linear_index(linear_index), .inside_res(inside_res)
  );

  // predictor's copy of the registers
  logic [2:0]  dims_reg;
  logic [10:0] extent_reg [FIELDS];
  logic        wrap_reg;

  cell_map_t expected_maps [$];
  int mismatches;
  int results_seen;
  int idle_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic cell_map_t map_cell(input logic signed [CW-1:0] c [FIELDS]);
    cell_map_t r;
    int n;
    longint sz;
    longint cc;
    longint u;
    longint mult;
    longint idx;
    logic [WW-1:0] w [FIELDS];
    r = '0;
    n = dims_reg;
    if (n < 1) n = 1;
    if (n > FIELDS) n = FIELDS;
    mult = 1;
    idx = 0;
    r.ins = 1'b1;
    for (int i = 0; i < FIELDS; i++) w[i] = '0;
    for (int i = 0; i < n; i++) begin
      sz = extent_reg[i];
      if (sz < 1) sz = 1;
      if (sz > 1024) sz = 1024;
      cc = c[i];
      if (cc < 0 || cc >= sz) r.ins = 1'b0;
      if (wrap_reg) begin
        u = cc % sz;
        if (u < 0) u += sz;
      end else begin
        u = cc;
      end
      w[i] = u[WW-1:0];
      idx += u * mult;
      mult *= sz;
    end
    r.w0 = w[0];
    r.w1 = w[1];
    r.w2 = w[2];
    r.w3 = w[3];
    r.lin = idx[IW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cell_map_t got, exp_map;
    if (!rst && done) begin
      got = '{wrapped_0, wrapped_1, wrapped_2, wrapped_3, linear_index, inside_res};
      results_seen++;
      if (expected_maps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        exp_map = expected_maps.pop_front();
        if (got !== exp_map) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: expected %p, got %p", $realtime, exp_map, got);
        end
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DIM_COUNT: dims_reg = val[2:0];
      REG_SIZE_0:    extent_reg[0] = val[10:0];
      REG_SIZE_1:    extent_reg[1] = val[10:0];
      REG_SIZE_2:    extent_reg[2] = val[10:0];
      REG_SIZE_3:    extent_reg[3] = val[10:0];
      REG_WRAP:      wrap_reg = val[0];
      default: ;
    endcase
  endtask

  // drains the pipe before any register write
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_maps.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic configure(input int d, input int s0, input int s1, input int s2,
                           input int s3, input bit wr);
    wait_idle();
    write_reg(REG_DIM_COUNT, 16'(d));
    write_reg(REG_SIZE_0, 16'(s0));
    write_reg(REG_SIZE_1, 16'(s1));
    write_reg(REG_SIZE_2, 16'(s2));
    write_reg(REG_SIZE_3, 16'(s3));
    write_reg(REG_WRAP, 16'(wr));
  endtask

  // start stays high after the transaction so the next one can follow directly
  task automatic send_coords(input int a, input int b, input int c, input int d);
    logic signed [CW-1:0] cv [FIELDS];
    cv[0] = CW'(a); cv[1] = CW'(b); cv[2] = CW'(c); cv[3] = CW'(d);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    coord_0 <= cv[0];
    coord_1 <= cv[1];
    coord_2 <= cv[2];
    coord_3 <= cv[3];
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_maps.push_back(map_cell(cv));
  endtask

  // coordinate near the configured extent most of the time, full range otherwise
  function automatic logic [CW-1:0] pick_coord(input int i);
    int sz;
    sz = extent_reg[i] == 0 ? 1 : extent_reg[i];
    if (sz > 1024) sz = 1024;
    case ($urandom_range(3))
      0: return CW'($urandom);
      1: return CW'($urandom_range(sz + 2) - 2);
      default: return CW'($urandom_range(sz - 1));
    endcase
  endfunction

  task automatic test_directed();
    logic [CW-1:0] lim [6] = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h03FF, 16'h0400};
    idle_pct = 0;
    // reset settings first
    send_coords(0, 0, 0, 0);
    send_coords(-1, 5, 9, 9);
    configure(4, 1024, 1024, 1024, 1024, 1);
    foreach (lim[i]) send_coords(lim[i], lim[5 - i], lim[i], lim[(i + 2) % 6]);
    configure(4, 1024, 1024, 1024, 1024, 0);
    foreach (lim[i]) send_coords(lim[i], lim[5 - i], lim[i], lim[(i + 2) % 6]);
    send_coords(16'h5555, 16'hAAAA, 16'h3333, 16'hCCCC);
    // zero size, oversize extent, dimension count zero and above four
    configure(0, 0, 2047, 3, 3, 1);
    send_coords(-7, 100, 1, 1);
    send_coords(3000, -3000, 2, 2);
    configure(7, 0, 2047, 1025, 7, 1);
    send_coords(-7, -2000, 1500, -1);
    configure(3, 7, 5, 3, 9, 0);
    send_coords(6, 4, 2, 8);
    send_coords(-1, -1, -1, 0);
    // unknown register indexes are ignored
    wait_idle();
    write_reg(reg_idx_t'(3'd6), 16'hFFFF);
    write_reg(reg_idx_t'(3'd7), 16'hFFFF);
    send_coords(7, 5, 3, 1);
  endtask

  task automatic test_random(input int count);
    int pct [4] = '{0, 57, 0, 13};
    for (int ph = 0; ph < 6; ph++) begin
      configure($urandom_range(7), $urandom_range(2047), $urandom_range(1100),
                $urandom_range(64), $urandom_range(20), $urandom_range(1));
      if (ph == 5) configure(4, 1024, 1024, 1024, 1024, $urandom_range(1));
      idle_pct = pct[ph % 4];
      for (int k = 0; k < count / 6; k++) begin
        if (k % 50 == 0) idle_pct = (k % 100 == 0) ? 0 : pct[ph % 4];
        send_coords(pick_coord(0), pick_coord(1), pick_coord(2), pick_coord(3));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    coord_0 = '0; coord_1 = '0; coord_2 = '0; coord_3 = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    dims_reg = 3'd2;
    foreach (extent_reg[i]) extent_reg[i] = 11'd1;
    wrap_reg = 1'b1;
    mismatches = 0;
    results_seen = 0;
    idle_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1500);
    wait_idle();
    $display("covered %0d mapped cells over directed extremes and random settings",
             results_seen);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/ccm_pkg.sv
sv/ccm_rem_stage.sv
sv/ccm_index.sv
sv/cell_coordinate_mapper_core.sv
tb/sv/cell_coordinate_mapper_core_tb.sv
